// ===== hw/rtl/voxel_chunk_face_culler_assert.svh =====
// assertion macros shared by the voxel chunk face culler checkers
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef VOXEL_CHUNK_FACE_CULLER_ASSERT_SVH
`define VOXEL_CHUNK_FACE_CULLER_ASSERT_SVH

// clocked property, off while reset is asserted
`define VCFC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("voxel culler check failed");

// same with a caller supplied message
`define VCFC_ASSERT_MSG(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`endif

// ===== hw/rtl/vcfc_pkg.sv =====
// shared constants for the voxel chunk face culler
// used by the top level and by its port checker, no dependencies
package vcfc_pkg;

  // command codes carried on tuser
  localparam logic [1:0] CMD_GEN   = 2'd0;
  localparam logic [1:0] CMD_SET   = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam int CMD_W     = 2;
  localparam int COORD_W   = 4;
  localparam int FACE_W    = 6;
  localparam int IN_DATA_W = 16;
  localparam int OUT_DATA_W = 8;

  // face mask bit positions
  localparam int FACE_POS_Z = 0;
  localparam int FACE_NEG_Z = 1;
  localparam int FACE_NEG_X = 2;
  localparam int FACE_POS_X = 3;
  localparam int FACE_NEG_Y = 4;
  localparam int FACE_POS_Y = 5;

  // terrain noise
  localparam int          NOISE_SHIFT = 13;
  localparam logic [31:0] NOISE_MUL   = 32'd60493;
  localparam logic [31:0] NOISE_ADD1  = 32'd19990303;
  localparam logic [31:0] NOISE_ADD2  = 32'd1376312589;
  localparam logic [31:0] NOISE_MASK  = 32'h7fff_ffff;
  localparam logic [6:0]  Y_BIAS      = 7'd10;

endpackage

// ===== hw/rtl/voxel_chunk_face_culler.sv =====
// voxel chunk occupancy store with hidden face culling
// depends on vcfc_pkg
//
// usage
//   input stream: tuser is the command (generate column, set block, query
//   faces), tdata holds the block coordinates and the new occupancy bit.
//   output stream: one item per input item, the visible face mask (query
//   only, else zero) and the occupancy of the addressed block after the command.
// sequencing
//   an item is taken only in the idle state, so the block takes no new item
//   until the last one has reached the output register; a single 32x32
//   multiplier and adder walks the noise chain for generate, and the single
//   read port of the column store sets the five column reads of a query;
//   a coordinate outside the chunk goes straight to the output step
// reset
//   after rst_ni releases, the column store is cleared one column a cycle,
//   all SIZE*SIZE columns, with s_axis_tready_o low
// stalls
//   a finished item waits in the output register while the next input item
//   is taken and worked on; the block then holds in its final step until the
//   output register is free
module voxel_chunk_face_culler
  import vcfc_pkg::*;
#(
  parameter int SIZE = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [3:0] pos_x, [7:4] pos_y, [11:8] pos_z, [12] active_in, [15:13] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // [1:0] command
  input  logic [CMD_W-1:0]      s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [5:0] face_mask, [6] block_active, [7] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  localparam int DEPTH = SIZE * SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(SIZE);

  // sequencer states
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_GEN   = 3'd2;
  localparam logic [2:0] ST_QRY   = 3'd3;
  localparam logic [2:0] ST_SET   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  // column store, bit y of a column is the block at height y
  logic [SIZE-1:0] mem_q [DEPTH];
  logic [SIZE-1:0] rd_q;

  logic [2:0]      state_q, state_d;
  logic [2:0]      step_q, step_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic            out_valid_q, out_valid_d;

  logic [1:0]      cmd_q, cmd_d;
  logic [CW-1:0]   x_q, x_d, y_q, y_d, z_q, z_d;
  logic            act_q, act_d;
  logic [31:0]     acc_q, acc_d;
  logic [31:0]     n_q, n_d;
  logic [SIZE-1:0] col_q, col_d;
  logic [FACE_W-1:0] mask_q, mask_d;
  logic            bit_q, bit_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  // raw input fields
  logic [COORD_W-1:0] fld_x, fld_y, fld_z;
  logic               fld_act, in_acc, out_of_range;

  assign fld_x   = s_axis_tdata_i[3:0];
  assign fld_y   = s_axis_tdata_i[7:4];
  assign fld_z   = s_axis_tdata_i[11:8];
  assign fld_act = s_axis_tdata_i[12];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_of_range    = (int'(fld_x) >= SIZE) || (int'(fld_y) >= SIZE) ||
                           (int'(fld_z) >= SIZE);

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  function automatic logic [AW-1:0] col_addr(input logic [CW-1:0] xv,
                                             input logic [CW-1:0] zv);
    col_addr = AW'(32'(xv) * SIZE + 32'(zv));
  endfunction

  // neighbour coordinates and chunk boundary flags
  logic [CW-1:0] x_up, x_dn, y_up, y_dn, z_up, z_dn;
  logic          x_first, x_last, y_first, y_last, z_first, z_last;
  logic [AW-1:0] a_ctr, a_zp, a_zn, a_xn, a_xp;

  assign x_up    = x_q + 1'b1;
  assign x_dn    = x_q - 1'b1;
  assign y_up    = y_q + 1'b1;
  assign y_dn    = y_q - 1'b1;
  assign z_up    = z_q + 1'b1;
  assign z_dn    = z_q - 1'b1;
  assign x_first = (x_q == '0);
  assign y_first = (y_q == '0);
  assign z_first = (z_q == '0);
  assign x_last  = (x_q == CW'(SIZE - 1));
  assign y_last  = (y_q == CW'(SIZE - 1));
  assign z_last  = (z_q == CW'(SIZE - 1));

  // boundary neighbours fall back to the centre column, never outside the store
  assign a_ctr = col_addr(x_q, z_q);
  assign a_zp  = z_last  ? a_ctr : col_addr(x_q, z_up);
  assign a_zn  = z_first ? a_ctr : col_addr(x_q, z_dn);
  assign a_xn  = x_first ? a_ctr : col_addr(x_dn, z_q);
  assign a_xp  = x_last  ? a_ctr : col_addr(x_up, z_q);

  // shared arithmetic unit, 32 bit wrapping multiply and add
  logic [31:0] mul_a, mul_b, mul_p, add_b, add_p, n_mix;

  assign mul_p = mul_a * mul_b;
  assign add_p = acc_q + add_b;
  assign n_mix = acc_q ^ (acc_q >> NOISE_SHIFT);

  // column from the noise value: block y is set when (y+10)*2^30 < 10*nn
  logic [34:0]     lim;
  logic [5:0]      lim_top;
  logic [SIZE-1:0] gen_col;

  assign lim     = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0};
  assign lim_top = 6'(lim[34:30]) + 6'(|lim[29:0]);

  always_comb begin
    for (int i = 0; i < SIZE; i++) begin
      gen_col[i] = ((7'(i) + Y_BIAS) < 7'(lim_top));
    end
  end

  // store port controls
  logic            mem_we;
  logic [AW-1:0]   mem_wa, mem_ra;
  logic [SIZE-1:0] mem_wd;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    cmd_d       = cmd_q;
    x_d         = x_q;
    y_d         = y_q;
    z_d         = z_q;
    act_d       = act_q;
    acc_d       = acc_q;
    n_d         = n_q;
    col_d       = col_q;
    mask_d      = mask_q;
    bit_d       = bit_q;
    mem_we      = 1'b0;
    mem_wa      = a_ctr;
    mem_wd      = col_q;
    mem_ra      = a_ctr;
    mul_a       = acc_q;
    mul_b       = acc_q;
    add_b       = NOISE_ADD1;

    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = '0;
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          cmd_d  = s_axis_tuser_i;
          x_d    = CW'(fld_x);
          y_d    = CW'(fld_y);
          z_d    = CW'(fld_z);
          act_d  = fld_act;
          step_d = '0;
          if (out_of_range) begin
            mask_d  = '0;
            bit_d   = 1'b0;
            state_d = ST_DONE;
          end else begin
            unique case (s_axis_tuser_i)
              CMD_GEN: state_d = ST_GEN;
              CMD_SET: state_d = ST_SET;
              default: state_d = ST_QRY;
            endcase
          end
        end
      end
      ST_GEN: begin
        step_d = step_q + 1'b1;
        case (step_q)
          3'd0: begin
            mul_a = 32'(x_q);
            mul_b = 32'(z_q);
            acc_d = mul_p;
          end
          3'd1: begin
            mul_a = n_mix;
            mul_b = n_mix;
            n_d   = n_mix;
            acc_d = mul_p;
          end
          3'd2: begin
            mul_b = NOISE_MUL;
            acc_d = mul_p;
          end
          3'd3: begin
            add_b = NOISE_ADD1;
            acc_d = add_p;
          end
          3'd4: begin
            mul_a = n_q;
            acc_d = mul_p;
          end
          3'd5: begin
            add_b = NOISE_ADD2;
            acc_d = add_p & NOISE_MASK;
          end
          3'd6: begin
            col_d = gen_col;
          end
          default: begin
            mem_we  = 1'b1;
            mem_wd  = col_q;
            mask_d  = '0;
            bit_d   = col_q[y_q];
            state_d = ST_DONE;
          end
        endcase
      end
      ST_QRY: begin
        // one read a step, data lands in rd_q the step after
        step_d = step_q + 1'b1;
        case (step_q)
          3'd0: mem_ra = a_ctr;
          3'd1: begin
            mem_ra = a_zp;
            col_d  = rd_q;
          end
          3'd2: begin
            mem_ra             = a_zn;
            mask_d[FACE_POS_Z] = z_last || !rd_q[y_q];
          end
          3'd3: begin
            mem_ra             = a_xn;
            mask_d[FACE_NEG_Z] = z_first || !rd_q[y_q];
          end
          3'd4: begin
            mem_ra             = a_xp;
            mask_d[FACE_NEG_X] = x_first || !rd_q[y_q];
          end
          default: begin
            mask_d[FACE_POS_X] = x_last || !rd_q[y_q];
            mask_d[FACE_NEG_Y] = y_first || !col_q[y_dn];
            mask_d[FACE_POS_Y] = y_last || !col_q[y_up];
            bit_d              = col_q[y_q];
            if (cmd_q != CMD_QUERY) begin
              mask_d = '0;
            end
            state_d = ST_DONE;
          end
        endcase
      end
      ST_SET: begin
        step_d = step_q + 1'b1;
        if (step_q != '0) begin
          mem_we      = 1'b1;
          mem_wd      = rd_q;
          mem_wd[y_q] = act_q;
          mask_d      = '0;
          bit_d       = act_q;
          state_d     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = {1'b0, bit_q, mask_q};
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // column store, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_q <= mem_q[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      step_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    cmd_q      <= cmd_d;
    x_q        <= x_d;
    y_q        <= y_d;
    z_q        <= z_d;
    act_q      <= act_d;
    acc_q      <= acc_d;
    n_q        <= n_d;
    col_q      <= col_d;
    mask_q     <= mask_d;
    bit_q      <= bit_d;
  end

endmodule

// ===== hw/rtl/vcfc_checker.sv =====
// port level checks for the voxel chunk face culler, bound to the top level
// depends on vcfc_pkg and voxel_chunk_face_culler_assert.svh
`include "voxel_chunk_face_culler_assert.svh"

module vcfc_checker
  import vcfc_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_tvalid_i,
  input logic                  s_tready_i,
  input logic [CMD_W-1:0]      s_tuser_i,
  input logic                  m_tvalid_i,
  input logic                  m_tready_i,
  input logic [OUT_DATA_W-1:0] m_tdata_i
);

  logic       in_acc, out_acc;
  logic [1:0] cnt_q, cnt_d, cnt_pop;
  logic [1:0] head_cmd_q, tail_cmd_q;

  assign in_acc  = s_tvalid_i && s_tready_i;
  assign out_acc = m_tvalid_i && m_tready_i;
  assign cnt_pop = cnt_q - 2'(out_acc);
  assign cnt_d   = cnt_pop + 2'(in_acc);

  // items in flight and their commands, oldest first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_acc) begin
      head_cmd_q <= tail_cmd_q;
    end
    if (in_acc) begin
      if (cnt_pop == '0) begin
        head_cmd_q <= s_tuser_i;
      end else begin
        tail_cmd_q <= s_tuser_i;
      end
    end
  end

  `VCFC_ASSERT(a_one_item_in_work, in_acc |=> !s_tready_i)
  `VCFC_ASSERT(a_no_extra_result, m_tvalid_i |-> (cnt_q != 2'd0))
  `VCFC_ASSERT_MSG(a_mask_only_on_query, (m_tvalid_i && cnt_q != 2'd0 && head_cmd_q != CMD_QUERY) |-> (m_tdata_i[FACE_W-1:0] == '0), "face mask set on a non-query item")
  `VCFC_ASSERT(a_out_held, (m_tvalid_i && !m_tready_i) |=> (m_tvalid_i && $stable(m_tdata_i)))

endmodule

bind voxel_chunk_face_culler vcfc_checker u_vcfc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .s_tuser_i  (s_axis_tuser_i),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o)
);
